### sv/lphs_pkg.sv
// Shared types and constants of the linear-probing hash set.
// Depends on nothing; imported by linear_probe_hash_set_top.
`default_nettype none

package lphs_pkg;

    localparam int OPCODE_W   = 2;
    localparam int KEY_W      = 64;
    localparam int TAG_W      = 16;
    localparam int S_TDATA_W  = 88;   // 82 payload bits, zero padded to whole bytes
    localparam int M_TDATA_W  = 24;   // 19 payload bits, zero padded to whole bytes

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SLOT  = 5'b00100,
        ST_ENT   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic             full_error;
        logic             inserted;
        logic [TAG_W-1:0] found_tag;
        logic             found;
    } result_t;

    // Xor fold of the key; the caller keeps the low slot-index bits.
    function automatic logic [KEY_W-1:0] hash_fold(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k ^ (k >> 32);
        h = h ^ (h >> 16);
        return h;
    endfunction

endpackage

`default_nettype wire

### sv/linear_probe_hash_set_top.sv
// Linear-probing hash set of 64-bit keys with a tag per entry.
// Depends on lphs_pkg for the opcode, state and result types and the hash fold.
// Each probe reads the slot, then the entry that it points to; an item stops at an empty
//   slot or at an entry whose key matches.
// Throughput: one item at a time; no beat is taken until the last item has finished.
// A clear passes through the done state and then sweeps one slot per cycle (512 with the defaults).
// Reset: aresetn is synchronous, active low; after it the same sweep empties the slot table,
//   and no beat is accepted until the sweep has finished.
`default_nettype none

module linear_probe_hash_set_top #(
    parameter int CAPACITY = 256,
    parameter int TAG_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input beat: opcode [1:0], key [65:2], tag [81:66], zero above.
    input  wire logic [lphs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Result beat: found [0], found_tag [16:1], inserted [17], full_error [18], zero above.
    output logic [lphs_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import lphs_pkg::*;

    // The slot table holds twice the capacity, rounded up to a power of two, so that at
    // least half of it is always empty and every probe run ends at an empty slot.
    localparam int SLOT_W = $clog2(2 * CAPACITY);
    localparam int SLOTS  = 1 << SLOT_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);   // slot value: 0 empty, else entry + 1
    localparam int EIDX_W = $clog2(CAPACITY);

    // Memories. The slot table maps hash positions to entry numbers; the entry store keeps
    // keys and tags in insertion order. Only entries below the count are ever compared.
    logic [CNT_W-1:0]    slot_mem [SLOTS];
    logic [KEY_W-1:0]    key_mem  [CAPACITY];
    logic [TAG_BITS-1:0] tag_mem  [CAPACITY];

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   sweep_reg, sweep_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    opcode_t             op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    result_t             res_reg, res_next;
    logic                clear_reg, clear_next;
    logic                m_tvalid_reg, m_tvalid_next;
    result_t             m_res_reg, m_res_next;

    // Memory ports and their registered read data.
    logic                slot_we;
    logic [SLOT_W-1:0]   slot_addr;
    logic [CNT_W-1:0]    slot_wdata;
    logic [CNT_W-1:0]    slot_rd_reg;
    logic                ent_we;
    logic [EIDX_W-1:0]   ent_addr;
    logic [KEY_W-1:0]    ekey_rd_reg;
    logic [TAG_BITS-1:0] etag_rd_reg;

    logic [KEY_W-1:0]    in_key;
    logic [TAG_W-1:0]    in_tag;
    logic [31:0]         in_tag_ext;
    logic [31:0]         rd_tag_ext;
    logic [KEY_W-1:0]    in_hash;
    logic [CNT_W-1:0]    slot_minus_one;
    logic                out_free;

    assign in_key         = s_tdata[KEY_W+OPCODE_W-1:OPCODE_W];
    assign in_tag         = s_tdata[TAG_W+KEY_W+OPCODE_W-1:KEY_W+OPCODE_W];
    assign in_tag_ext     = 32'(in_tag);
    assign rd_tag_ext     = 32'(etag_rd_reg);
    assign in_hash        = hash_fold(in_key);
    assign slot_minus_one = slot_rd_reg - CNT_W'(1);

    // The output register parts the result from the next item: a finished result may wait
    // for the downstream side while the block already takes and probes the next key.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        tag_next      = tag_reg;
        pos_next      = pos_reg;
        res_next      = res_reg;
        clear_next    = clear_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_res_next    = m_res_reg;
        slot_we       = 1'b0;
        slot_addr     = pos_reg;
        slot_wdata    = '0;
        ent_we        = 1'b0;
        ent_addr      = slot_minus_one[EIDX_W-1:0];

        unique case (state_reg)
            ST_SWEEP: begin
                // Empty one slot per cycle; after reset and after every clear.
                slot_we    = 1'b1;
                slot_addr  = sweep_reg;
                sweep_next = sweep_reg + SLOT_W'(1);
                if (sweep_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                slot_addr = in_hash[SLOT_W-1:0];
                if (s_tvalid) begin
                    op_next    = opcode_t'(s_tdata[OPCODE_W-1:0]);
                    key_next   = in_key;
                    tag_next   = in_tag_ext[TAG_BITS-1:0];
                    pos_next   = in_hash[SLOT_W-1:0];
                    res_next   = '0;
                    clear_next = 1'b0;
                    case (opcode_t'(s_tdata[OPCODE_W-1:0]))
                        OP_INSERT, OP_LOOKUP: begin
                            state_next = ST_SLOT;
                        end
                        OP_CLEAR: begin
                            clear_next = 1'b1;
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SLOT: begin
                if (slot_rd_reg == '0) begin
                    // Key absent: an insert takes the empty slot if the store has room.
                    if (op_reg == OP_INSERT) begin
                        if (count_reg < CNT_W'(CAPACITY)) begin
                            slot_we             = 1'b1;
                            slot_wdata          = count_reg + CNT_W'(1);
                            ent_we              = 1'b1;
                            ent_addr            = count_reg[EIDX_W-1:0];
                            count_next          = count_reg + CNT_W'(1);
                            res_next.inserted   = 1'b1;
                        end else begin
                            res_next.full_error = 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ENT;
                end
            end
            ST_ENT: begin
                if (ekey_rd_reg == key_reg) begin
                    res_next.found     = 1'b1;
                    res_next.found_tag = rd_tag_ext[TAG_W-1:0];
                    state_next         = ST_DONE;
                end else begin
                    // Next slot, wrapping at the end of the table.
                    pos_next   = pos_reg + SLOT_W'(1);
                    slot_addr  = pos_reg + SLOT_W'(1);
                    state_next = ST_SLOT;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = res_reg;
                    if (clear_reg) begin
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_SWEEP;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            sweep_reg    <= '0;
            count_reg    <= '0;
            clear_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            count_reg    <= count_next;
            clear_reg    <= clear_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        tag_reg   <= tag_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    // Slot table: one address per cycle, read data in the next cycle. Only one item is in
    // flight, so a write and a later read of the same slot never overlap.
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_addr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_addr];
    end

    // Entry store: written at the count on insert, read at the entry a slot points to.
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            key_mem[ent_addr] <= key_reg;
            tag_mem[ent_addr] <= tag_reg;
        end
        ekey_rd_reg <= key_mem[ent_addr];
        etag_rd_reg <= tag_mem[ent_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_res_reg.full_error, m_res_reg.inserted,
                                  m_res_reg.found_tag, m_res_reg.found});

    // The entry count never passes the capacity of the entry store.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // An insert only ever claims a slot that the probe found empty.
    a_slot_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_we && state_reg == ST_SLOT) |-> slot_rd_reg == '0)
        else $error("insert overwrote an occupied slot");

    // A result never reports a hit together with an insertion or a refusal.
    a_result_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_res_reg.found && (m_res_reg.inserted || m_res_reg.full_error))
                     && !(m_res_reg.inserted && m_res_reg.full_error))
        else $error("contradictory result flags");

    // A miss carries no tag.
    a_miss_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_res_reg.found) |-> m_res_reg.found_tag == '0)
        else $error("tag reported without a hit");

endmodule

`default_nettype wire
